FILE: design/dnle_pkg.sv
// shared types, constants and helpers for the dns name label encoder
// no dependencies
package dnle_pkg;

  localparam int unsigned MAX_LABEL  = 62;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned FULL_ADR_W = CNT_W + 1;
  localparam int unsigned ELEN_W     = 10;
  localparam logic [7:0]  DOT_CHAR   = 8'h2E;
  localparam logic [ELEN_W-1:0] LEN_SAT = '1;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_name;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              last;
    logic              label_truncated;
    logic [ELEN_W-1:0] encoded_length;
  } out_item_t;

  // one flush request from front to back
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic             trunc;
    logic             last;
  } cmd_t;

  // back tells front that a buffer bank was fully replayed
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LEN,
    BK_DATA,
    BK_TERM
  } back_state_e;

  // bank 1 sits right above bank 0 in the label buffer
  function automatic logic [FULL_ADR_W-1:0] buf_addr(logic bank, logic [CNT_W-1:0] idx,
                                                     logic [CNT_W-1:0] base);
    logic [FULL_ADR_W-1:0] off;
    off = bank ? {1'b0, base} : '0;
    return off + {1'b0, idx};
  endfunction

endpackage

FILE: design/dnle_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module dnle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 124,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/dnle_cmd_fifo.sv
// two entry queue of flush requests between front and back
// depends on dnle_pkg
module dnle_cmd_fifo import dnle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_data_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o     = (fill_q == 2'd2);
  assign empty_o    = (fill_q == 2'd0);
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/dnle_front.sv
// front part: takes characters, fills the current buffer bank, issues flush requests
// depends on dnle_pkg
module dnle_front import dnle_pkg::*; #(
  parameter int unsigned MaxLabel = MAX_LABEL,
  localparam int unsigned AddrW = $clog2(2 * MaxLabel)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  in_item_t         in_data_i,
  output logic             in_stall_o,
  output logic             we_o,
  output logic [AddrW-1:0] waddr_o,
  output logic [7:0]       wdata_o,
  output logic             push_o,
  output cmd_t             push_data_o,
  input  logic             full_i,
  input  release_t         release_i
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MaxLabel);

  logic             bank_q, bank_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [1:0]       busy_q, busy_d;
  logic             accept;
  logic             is_dot;
  logic             flush;
  logic [FULL_ADR_W-1:0] addr_full;

  // wait while the queue is full or the back still replays the bank we would fill
  assign in_stall_o = full_i || busy_q[bank_q];
  assign accept     = in_valid_i && !in_stall_o;
  assign is_dot     = (in_data_i.char_in == DOT_CHAR);
  assign flush      = in_data_i.end_of_name || is_dot;

  assign addr_full = buf_addr(bank_q, count_q, MaxCnt);
  assign waddr_o   = addr_full[AddrW-1:0];
  assign wdata_o   = in_data_i.char_in;
  assign we_o      = accept && !flush && (count_q < MaxCnt);

  // an end item always goes to the back for the terminator, a dot only with characters
  assign push_o = accept && (in_data_i.end_of_name || (is_dot && count_q != '0));
  assign push_data_o = '{bank: bank_q, count: count_q, trunc: ovf_q,
                         last: in_data_i.end_of_name};

  always_comb begin
    bank_d  = bank_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    busy_d  = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (accept) begin
      if (flush) begin
        if (count_q != '0) begin
          busy_d[bank_q] = 1'b1;
          bank_d         = ~bank_q;
        end
        count_d = '0;
        ovf_d   = 1'b0;
      end else if (count_q < MaxCnt) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= 1'b0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 2'b00;
    end else begin
      bank_q  <= bank_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      busy_q  <= busy_d;
    end
  end

endmodule

FILE: design/dnle_back.sv
// back part: replays a buffered label as length byte and characters, adds the terminator
// depends on dnle_pkg
module dnle_back import dnle_pkg::*; #(
  parameter int unsigned MaxLabel = MAX_LABEL,
  localparam int unsigned AddrW = $clog2(2 * MaxLabel)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  cmd_t             cmd_i,
  output logic             pop_o,
  output logic             re_o,
  output logic [AddrW-1:0] raddr_o,
  input  logic [7:0]       rdata_i,
  output release_t         release_o,
  output logic             out_valid_o,
  output out_item_t        out_data_o,
  input  logic             out_stall_i
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MaxLabel);

  back_state_e       state_q, state_d;
  cmd_t              cmd_q;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [ELEN_W-1:0] nbytes_q, nbytes_d;
  logic              out_valid_q;
  out_item_t         out_q;
  logic              slot_free;
  logic              emit;
  out_item_t         emit_item;
  logic [CNT_W-1:0]  idx_next;
  logic              more;
  logic [CNT_W-1:0]  rd_idx;
  logic [FULL_ADR_W-1:0] addr_full;
  logic [ELEN_W-1:0] nbytes_inc;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign idx_next   = idx_q + CNT_W'(1);
  assign more       = (idx_next < cmd_q.count);
  assign nbytes_inc = (nbytes_q == LEN_SAT) ? LEN_SAT : nbytes_q + ELEN_W'(1);
  assign addr_full  = buf_addr(cmd_q.bank, rd_idx, MaxCnt);
  assign raddr_o    = addr_full[AddrW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          state_d = (cmd_i.count != '0) ? BK_LEN : BK_TERM;
        end
      end
      BK_LEN: begin
        if (slot_free) begin
          state_d = BK_DATA;
        end
      end
      BK_DATA: begin
        if (slot_free && !more) begin
          state_d = cmd_q.last ? BK_TERM : BK_IDLE;
        end
      end
      BK_TERM: begin
        if (slot_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o     = 1'b0;
    re_o      = 1'b0;
    rd_idx    = '0;
    emit      = 1'b0;
    emit_item = '0;
    release_o = '{valid: 1'b0, bank: cmd_q.bank};
    idx_d     = idx_q;
    case (state_q)
      BK_IDLE: begin
        pop_o = !empty_i;
      end
      BK_LEN: begin
        if (slot_free) begin
          emit                      = 1'b1;
          emit_item.out_byte        = 8'(cmd_q.count);
          emit_item.label_truncated = cmd_q.trunc;
          // prefetch the first character alongside the length byte
          re_o  = 1'b1;
          idx_d = '0;
        end
      end
      BK_DATA: begin
        if (slot_free) begin
          emit               = 1'b1;
          emit_item.out_byte = rdata_i;
          if (more) begin
            re_o   = 1'b1;
            rd_idx = idx_next;
            idx_d  = idx_next;
          end else begin
            release_o.valid = 1'b1;
          end
        end
      end
      BK_TERM: begin
        if (slot_free) begin
          emit                     = 1'b1;
          emit_item.last           = 1'b1;
          emit_item.encoded_length = nbytes_inc;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    nbytes_d = nbytes_q;
    if (emit) begin
      nbytes_d = emit_item.last ? '0 : nbytes_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      nbytes_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      nbytes_q <= nbytes_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (emit) begin
      out_q <= emit_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/dns_name_label_encoder.sv
// top level of the dns name label encoder
// depends on dnle_pkg, dnle_front, dnle_cmd_fifo, dnle_back, dnle_ram
//
// input channel: one host name character per request, or an end-of-name
// request that closes the name. output channel: one encoded byte per request,
// a length byte before each label's characters, then a zero terminator with
// last set and the total encoded length (saturating at 1023).
// both channels use valid/stall; a request moves when valid is high and stall low.
// the front takes one character per cycle, unless stalled, into a two-bank label buffer.
// a dot or end request queues a flush; the back pops each flush request, sends
// the length byte, then replays the bank through the buffer's single read port
// at one byte per cycle while the receiver does not stall, and sends the
// terminator after an end request. the front keeps filling the other bank
// meanwhile and stalls only when both banks wait for replay or the two-entry
// flush queue is full. the first output byte of a label appears once the flush
// request has passed the queue, the back's idle and length states and the
// output register.
// reset empties the queue, drops any partial label and clears the byte count.
// when the receiver stalls, the output register holds its byte, the back
// waits, and the front runs on until the queue or the banks fill up.
module dns_name_label_encoder import dnle_pkg::*; #(
  parameter int unsigned MaxLabel = MAX_LABEL
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i
);

  localparam int unsigned Depth = 2 * MaxLabel;
  localparam int unsigned AddrW = $clog2(Depth);

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [7:0]       wdata;
  logic             re;
  logic [AddrW-1:0] raddr;
  logic [7:0]       rdata;
  logic             push;
  cmd_t             push_data;
  logic             full;
  logic             pop;
  logic             empty;
  cmd_t             pop_data;
  release_t         rel;

  dnle_front #(.MaxLabel(MaxLabel)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full),
    .release_i   (rel)
  );

  dnle_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  dnle_ram #(.Width(8), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  dnle_back #(.MaxLabel(MaxLabel)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (pop_data),
    .pop_o       (pop),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .release_o   (rel),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  // the terminator is a plain zero byte with no truncation flag
  a_term_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |->
      out_data_o.out_byte == 8'h00 && !out_data_o.label_truncated)
    else $error("terminator carries a nonzero byte or truncation flag");

  // the length only shows on the terminator
  a_len_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.encoded_length == '0)
    else $error("encoded length outside the terminator");

  // a truncated label always reports the full limit
  a_trunc_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.label_truncated |-> out_data_o.out_byte == 8'(MaxLabel))
    else $error("truncated label with wrong length byte");

  // the queue is never written while full nor read while empty
  a_queue_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full) && !(pop && empty))
    else $error("flush queue overflow or underflow");

endmodule
